[rtl/core/dov_pkg.sv]
package dov_pkg;

	localparam logic [7:0] CODE_PAD      = 8'd0;
	localparam logic [7:0] CODE_END      = 8'd255;
	localparam logic [7:0] CODE_MSG_TYPE = 8'd53;

	localparam logic [1:0] PH_CODE  = 2'd0;
	localparam logic [1:0] PH_LEN   = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_NO_LEN   = 3'd1,
		ERR_ZERO_LEN = 3'd2,
		ERR_OVERRUN  = 3'd3,
		ERR_BAD_LEN  = 3'd4,
		ERR_NO_END   = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		LEN_ANY  = 3'd0,
		LEN_ONE  = 3'd1,
		LEN_FOUR = 3'd2,
		LEN_EVEN = 3'd3,
		LEN_MUL4 = 3'd4,
		LEN_MUL8 = 3'd5
	} len_rule_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] code;
		logic [7:0] left;
		logic       first;
		logic [7:0] ctype;
		err_t       err;
	} walk_state_t;

	localparam walk_state_t WALK_RESET = '{
		phase: PH_CODE, code: 8'd0, left: 8'd0, first: 1'b0,
		ctype: 8'd0, err: ERR_NONE
	};

	typedef struct packed {
		logic       well_formed;
		err_t       error_kind;
		logic [7:0] msg_type;
	} verdict_t;

	function automatic len_rule_t len_rule(input logic [7:0] code);
		len_rule_t r;
		r = LEN_ANY;
		case (code)
			8'd1, 8'd2, 8'd16, 8'd24, 8'd28, 8'd32, 8'd35, 8'd38, 8'd50, 8'd51,
			8'd54, 8'd58, 8'd59:
				r = LEN_FOUR;
			8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd41, 8'd42,
			8'd44, 8'd45, 8'd48, 8'd49, 8'd65, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72,
			8'd73, 8'd74, 8'd75, 8'd76:
				r = LEN_MUL4;
			8'd19, 8'd20, 8'd23, 8'd27, 8'd29, 8'd30, 8'd31, 8'd34, 8'd36, 8'd37,
			8'd39, 8'd46, 8'd52, 8'd53:
				r = LEN_ONE;
			8'd21, 8'd33:
				r = LEN_MUL8;
			8'd25:
				r = LEN_EVEN;
			default:
				r = LEN_ANY;
		endcase
		return r;
	endfunction

	function automatic logic len_ok(input logic [7:0] code, input logic [7:0] len);
		logic ok;
		ok = 1'b1;
		unique case (len_rule(code))
			LEN_ONE:  ok = (len == 8'd1);
			LEN_FOUR: ok = (len == 8'd4);
			LEN_EVEN: ok = (len[0] == 1'b0);
			LEN_MUL4: ok = (len[1:0] == 2'd0);
			LEN_MUL8: ok = (len[2:0] == 3'd0);
			default:  ok = 1'b1;
		endcase
		return ok;
	endfunction

endpackage

[rtl/core/dov_step.sv]
module dov_step
	import dov_pkg::*;
(
	input  walk_state_t cur,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output walk_state_t nxt,
	output verdict_t    verdict
);

	walk_state_t w;

	always_comb begin
		w = cur;
		unique case (cur.phase)
			PH_CODE: begin
				if (data_byte == CODE_PAD) begin
					w = cur;
				end else if (data_byte == CODE_END) begin
					w.phase = PH_DONE;
				end else if (last_byte) begin
					w.err   = ERR_NO_LEN;
					w.phase = PH_DONE;
				end else begin
					w.code  = data_byte;
					w.phase = PH_LEN;
				end
			end
			PH_LEN: begin
				if (data_byte == 8'd0) begin
					w.err   = ERR_ZERO_LEN;
					w.phase = PH_DONE;
				end else if (last_byte) begin
					w.err   = ERR_OVERRUN;
					w.phase = PH_DONE;
				end else if (!len_ok(cur.code, data_byte)) begin
					w.err   = ERR_BAD_LEN;
					w.phase = PH_DONE;
				end else begin
					w.left  = data_byte;
					w.first = 1'b1;
					w.phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (cur.first && cur.code == CODE_MSG_TYPE) begin
					w.ctype = data_byte;
				end
				w.first = 1'b0;
				w.left  = cur.left - 8'd1;
				if (w.left == 8'd0) begin
					w.phase = PH_CODE;
				end else if (last_byte) begin
					w.err   = ERR_OVERRUN;
					w.phase = PH_DONE;
				end
			end
			default: begin
				w = cur;
			end
		endcase

		if (w.err != ERR_NONE) begin
			verdict = '{well_formed: 1'b0, error_kind: w.err, msg_type: 8'd0};
		end else if (w.phase == PH_DONE) begin
			verdict = '{well_formed: 1'b1, error_kind: ERR_NONE, msg_type: w.ctype};
		end else begin
			verdict = '{well_formed: 1'b0, error_kind: ERR_NO_END, msg_type: 8'd0};
		end

		nxt = last_byte ? WALK_RESET : w;
	end

endmodule

[rtl/core/dhcp_option_validator.sv]
// Channel   Handshake            Fields
// request   in_valid / in_stall  data_byte[7:0], last_byte
// verdict   out_valid / out_stall well_formed, error_kind[2:0], msg_type[7:0]
//
// One byte per cycle while no last byte is stalled. A taken last byte passes through the
// input register and then the verdict register, around one table lookup and length
// update.
// arst_n clears the walk state and both valid flags; the next byte starts a buffer.
// A held verdict stalls only a waiting last byte; other bytes keep flowing.
module dhcp_option_validator
	import dov_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       well_formed,
	output logic [2:0] error_kind,
	output logic [7:0] msg_type
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	walk_state_t state_q;
	walk_state_t state_nxt;
	verdict_t    verdict;
	verdict_t    verdict_q;
	logic        out_valid_q;
	logic        out_free;
	logic        go_s1;
	logic        accept;

	assign out_free = !out_valid_q || !out_stall;
	assign go_s1    = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !go_s1;
	assign accept   = in_valid && !in_stall;

	dov_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.verdict   (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= WALK_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			if (go_s1) begin
				state_q <= state_nxt;
			end
			if (go_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (go_s1 && last_s1) begin
			verdict_q <= verdict;
		end
	end

	assign out_valid   = out_valid_q;
	assign well_formed = verdict_q.well_formed;
	assign error_kind  = verdict_q.error_kind;
	assign msg_type    = verdict_q.msg_type;

endmodule

[tb/sv/tb_dhcp_option_validator.sv]
`timescale 1ns / 1ps

module tb_dhcp_option_validator
	import dov_pkg::*;
();

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES = 400;

	typedef logic [7:0] frame_t[$];

	class verdict_board;
		logic [1:0] walk_phase;
		logic [7:0] opt_code;
		logic [7:0] remaining;
		bit         first_val;
		logic [7:0] held_type;
		err_t       fault;
		verdict_t   due[$];
		int         mismatches;

		function new();
			clear();
			mismatches = 0;
		endfunction

		function void clear();
			walk_phase = PH_CODE;
			opt_code = 8'd0;
			remaining = 8'd0;
			first_val = 1'b0;
			held_type = 8'd0;
			fault = ERR_NONE;
		endfunction

		function len_rule_t rule_of(logic [7:0] c);
			case (c)
				8'd19, 8'd20, 8'd23, 8'd27, 8'd29, 8'd30, 8'd31, 8'd34, 8'd36,
				8'd37, 8'd39, 8'd46, 8'd52, 8'd53:
					return LEN_ONE;
				8'd1, 8'd2, 8'd16, 8'd24, 8'd28, 8'd32, 8'd35, 8'd38, 8'd50,
				8'd51, 8'd54, 8'd58, 8'd59:
					return LEN_FOUR;
				8'd25:
					return LEN_EVEN;
				8'd21, 8'd33:
					return LEN_MUL8;
				default: begin
					if ((c >= 8'd3 && c <= 8'd11) || (c >= 8'd68 && c <= 8'd76) ||
					    c == 8'd41 || c == 8'd42 || c == 8'd44 || c == 8'd45 ||
					    c == 8'd48 || c == 8'd49 || c == 8'd65)
						return LEN_MUL4;
					return LEN_ANY;
				end
			endcase
		endfunction

		function bit len_fits(logic [7:0] c, logic [7:0] n);
			case (rule_of(c))
				LEN_ONE:  return n == 8'd1;
				LEN_FOUR: return n == 8'd4;
				LEN_EVEN: return n[0] == 1'b0;
				LEN_MUL4: return n[1:0] == 2'd0;
				LEN_MUL8: return n[2:0] == 3'd0;
				default:  return 1'b1;
			endcase
		endfunction

		function void abort_walk(err_t k);
			fault = k;
			walk_phase = PH_DONE;
		endfunction

		function void take_request(logic [7:0] b, logic l);
			verdict_t v;
			case (walk_phase)
				PH_CODE: begin
					if (b == CODE_PAD) begin
					end else if (b == CODE_END) begin
						walk_phase = PH_DONE;
					end else if (l) begin
						abort_walk(ERR_NO_LEN);
					end else begin
						opt_code = b;
						walk_phase = PH_LEN;
					end
				end
				PH_LEN: begin
					if (b == 8'd0)
						abort_walk(ERR_ZERO_LEN);
					else if (l)
						abort_walk(ERR_OVERRUN);
					else if (!len_fits(opt_code, b))
						abort_walk(ERR_BAD_LEN);
					else begin
						remaining = b;
						first_val = 1'b1;
						walk_phase = PH_VALUE;
					end
				end
				PH_VALUE: begin
					if (first_val && opt_code == CODE_MSG_TYPE)
						held_type = b;
					first_val = 1'b0;
					remaining = remaining - 8'd1;
					if (remaining == 8'd0)
						walk_phase = PH_CODE;
					else if (l)
						abort_walk(ERR_OVERRUN);
				end
				default: begin
				end
			endcase
			if (!l)
				return;
			if (fault != ERR_NONE) begin
				v.well_formed = 1'b0;
				v.error_kind = fault;
				v.msg_type = 8'd0;
			end else if (walk_phase == PH_DONE) begin
				v.well_formed = 1'b1;
				v.error_kind = ERR_NONE;
				v.msg_type = held_type;
			end else begin
				v.well_formed = 1'b0;
				v.error_kind = ERR_NO_END;
				v.msg_type = 8'd0;
			end
			due.push_back(v);
			clear();
		endfunction

		function void check_verdict(logic wf, logic [2:0] ek, logic [7:0] rt);
			verdict_t v;
			if (due.size() == 0) begin
				$display("%0t: unexpected verdict: well_formed %b error_kind %0d msg_type %0d",
					$time, wf, ek, rt);
				mismatches++;
				return;
			end
			v = due.pop_front();
			if (wf !== v.well_formed) begin
				$display("%0t: well_formed expected %b actual %b", $time, v.well_formed, wf);
				mismatches++;
			end
			if (ek !== v.error_kind) begin
				$display("%0t: error_kind expected %0d actual %0d", $time, v.error_kind, ek);
				mismatches++;
			end
			if (rt !== v.msg_type) begin
				$display("%0t: msg_type expected %0d actual %0d",
					$time, v.msg_type, rt);
				mismatches++;
			end
		endfunction

		function int waiting();
			return due.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'd0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       well_formed;
	logic [2:0] error_kind;
	logic [7:0] msg_type;

	int send_idle = 0;
	int recv_idle = 0;
	bit pressure_go = 1'b0;

	verdict_board sb = new();

	dhcp_option_validator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.well_formed(well_formed),
		.error_kind (error_kind),
		.msg_type   (msg_type)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// verdict side: check, then pick the stall for the next cycle
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
				sb.check_verdict(well_formed, error_kind, msg_type);
			if (pressure_go && !hold_taken) begin
				hold_left = HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle);
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sb.take_request(b, l);
	endtask

	task automatic send_frame(input frame_t frame);
		for (int i = 0; i < frame.size(); i++)
			push_byte(frame[i], i == frame.size() - 1);
	endtask

	task automatic run_random(input int n_bytes);
		frame_t     frame;
		int         sent;
		int         n_opt;
		int         len;
		int         cut;
		int         mess;
		logic [7:0] code;
		sent = 0;
		while (sent < n_bytes) begin
			frame = {};
			n_opt = $urandom_range(0, 5);
			for (int i = 0; i < n_opt; i++) begin
				case ($urandom_range(0, 9))
					0: frame.push_back(CODE_PAD);
					1: begin
						frame.push_back(CODE_MSG_TYPE);
						frame.push_back(8'd1);
						frame.push_back(8'($urandom));
					end
					default: begin
						if ($urandom_range(0, 1))
							code = 8'($urandom_range(1, 76));
						else
							code = 8'($urandom_range(1, 254));
						case (sb.rule_of(code))
							LEN_ONE:  len = 1;
							LEN_FOUR: len = 4;
							LEN_EVEN: len = 2 * $urandom_range(1, 4);
							LEN_MUL4: len = 4 * $urandom_range(1, 3);
							LEN_MUL8: len = 8 * $urandom_range(1, 2);
							default: begin
								if ($urandom_range(0, 49) == 0)
									len = $urandom_range(100, 255);
								else
									len = $urandom_range(1, 8);
							end
						endcase
						frame.push_back(code);
						frame.push_back(8'(len));
						for (int j = 0; j < len; j++)
							frame.push_back(8'($urandom));
					end
				endcase
			end
			if ($urandom_range(0, 9) != 0)
				frame.push_back(CODE_END);
			len = $urandom_range(0, 2);
			for (int j = 0; j < len; j++)
				frame.push_back(8'($urandom));
			if (frame.size() == 0)
				frame.push_back(8'($urandom));
			mess = $urandom_range(0, 99);
			if (mess < 15) begin
				cut = $urandom_range(1, frame.size());
				while (frame.size() > cut)
					void'(frame.pop_back());
			end else if (mess < 25) begin
				frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
			end
			send_frame(frame);
			sent += frame.size();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 11;
		recv_idle = 77;
		send_frame('{CODE_END});
		send_frame('{CODE_MSG_TYPE, 8'd1, 8'd5, CODE_END});
		send_frame('{CODE_PAD});
		send_frame('{8'd7});
		send_frame('{8'd3, 8'd0, CODE_END});
		send_frame('{8'd12, 8'd5});
		send_frame('{8'd1, 8'd3, 8'd9});
		send_frame('{8'd12, 8'd3, 8'hAA});
		send_frame('{CODE_MSG_TYPE, 8'd1, 8'hFF, CODE_MSG_TYPE, 8'd1, 8'd2, CODE_END, 8'h11});
		run_random(600);

		send_idle = 77;
		recv_idle = 11;
		run_random(600);

		// hold the verdict side off while short buffers keep coming
		send_idle = 0;
		recv_idle = 0;
		pressure_go = 1'b1;
		for (int i = 0; i < 80; i++) begin
			case ($urandom_range(0, 2))
				0: send_frame('{CODE_END});
				1: send_frame('{CODE_PAD});
				default: send_frame('{CODE_MSG_TYPE, 8'd1, 8'($urandom), CODE_END});
			endcase
		end
		run_random(350);

		in_valid <= 1'b0;
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/dov_pkg.sv
rtl/core/dov_step.sv
rtl/core/dhcp_option_validator.sv
tb/sv/tb_dhcp_option_validator.sv
